// ----- rtl/assert_macros.svh -----
// Assertion macros used by route_table_update.
// No dependencies; compiled in with ASSERT_OFF undefined to enable checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/rtu_pkg.sv -----
// Route table update: shared types, codes and table depth.
// No dependencies.
package rtu_pkg;

	localparam int TABLE_DEPTH = 16;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_EXISTED  = 3'd1,
		ST_WITHDREW = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ADD      = 1'b0,
		CMD_WITHDRAW = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  ifc;
		logic [15:0] weight;
	} route_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_MATCH_ADD,
		CELL_MATCH_DEL,
		CELL_INSERT,
		CELL_REPLACE,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		route_t   key;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} fsm_t;

endpackage

// ----- rtl/rtu_if.sv -----
// Route table update: request and response channel interfaces.
// Valid/ready handshake; no package dependency.
interface rtu_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] route_base;
	logic [31:0] route_mask;
	logic [31:0] route_gateway;
	logic [3:0]  interface_id;
	logic [15:0] route_weight;

	modport source (
		output valid, cmd, route_base, route_mask, route_gateway, interface_id, route_weight,
		input  ready
	);
	modport sink (
		input  valid, cmd, route_base, route_mask, route_gateway, interface_id, route_weight,
		output ready
	);
endinterface

interface rtu_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

// ----- rtl/rtu_cell.sv -----
// Route table update: one table slot with its compare flags and shift muxes.
// Depends on rtu_pkg; chained by route_table_update.
module rtu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rtu_pkg::cell_ctl_t ctl,
	input  logic              prev_valid,
	input  rtu_pkg::route_t   prev_entry,
	input  logic              next_valid,
	input  rtu_pkg::route_t   next_entry,
	input  logic              found_in,
	output logic              valid,
	output rtu_pkg::route_t   entry,
	output logic              found_out
);
	import rtu_pkg::*;

	logic   valid_q;
	logic   hit_q;
	logic   repl_q;
	route_t entry_q;
	logic   exact;
	logic   base_eq;
	logic   repl;
	logic   first;

	always_comb begin
		base_eq = entry_q.base == ctl.key.base;
		exact   = entry_q == ctl.key;
		repl    = base_eq && (entry_q.ifc == ctl.key.ifc) && (ctl.key.weight < entry_q.weight);
	end

	assign first     = hit_q && !found_in;
	assign found_out = found_in || hit_q;
	assign valid     = valid_q;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			repl_q  <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_MATCH_ADD: begin
					hit_q  <= valid_q && (exact || repl);
					repl_q <= valid_q && repl;
				end
				CELL_MATCH_DEL: begin
					hit_q  <= valid_q && base_eq;
					repl_q <= 1'b0;
				end
				CELL_INSERT: valid_q <= prev_valid;
				CELL_REMOVE: begin
					if (found_out) begin
						valid_q <= next_valid;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: entry_q <= prev_entry;
			CELL_REPLACE: begin
				if (first && repl_q) begin
					entry_q <= ctl.key;
				end
			end
			CELL_REMOVE: begin
				if (found_out) begin
					entry_q <= next_entry;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/route_table_update.sv -----
// Route table update: top level, a row of rtu_cell slots kept newest first.
// Depends on rtu_pkg, rtu_if, rtu_cell and assert_macros.svh.
//
//   port   dir    beat
//   req    sink   cmd, route_base, route_mask, route_gateway, interface_id, route_weight
//   rsp    source status
//
// Per beat: the accept edge latches per-cell compare flags, then the update edge
// ripples the first hit through the cells and shifts, overwrites or drops, and loads status.
// A new request is taken once the update edge has passed, while status may still wait.
// A stalled rsp holds the update cycle; the table does not change until status is free.
// Reset clears the valid bit of every cell; there is no clearing pass.
`include "assert_macros.svh"

module route_table_update (
	input  logic          clk,
	input  logic          arst_n,
	rtu_req_if.sink       req,
	rtu_rsp_if.source     rsp
);
	import rtu_pkg::*;

	fsm_t      state_q;
	fsm_t      state_d;
	cmd_t      cmd_q;
	route_t    req_q;
	route_t    key;
	cell_ctl_t ctl;
	status_t   status_q;
	status_t   status_d;
	logic      rsp_valid_q;
	logic      accept;
	logic      apply_go;
	logic      full;
	logic      found_any;
	logic      do_insert;
	logic      do_remove;
	int        valid_cnt;

	logic   [TABLE_DEPTH-1:0] valid_vec;
	logic   [TABLE_DEPTH:0]   found;
	route_t                   entry_vec [TABLE_DEPTH];

	assign accept    = req.valid && req.ready;
	assign apply_go  = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);
	assign full      = valid_vec[TABLE_DEPTH-1];
	assign found_any = found[TABLE_DEPTH];
	assign found[0]  = 1'b0;

	always_comb begin
		if (state_q == S_IDLE) begin
			key.base    = req.route_base;
			key.mask    = req.route_mask;
			key.gateway = req.route_gateway;
			key.ifc     = req.interface_id;
			key.weight  = req.route_weight;
		end else begin
			key = req_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (apply_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		ctl.op    = CELL_HOLD;
		ctl.key   = key;
		status_d  = ST_NEW;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ctl.op = (cmd_t'(req.cmd) == CMD_WITHDRAW) ? CELL_MATCH_DEL : CELL_MATCH_ADD;
				end
			end
			S_APPLY: begin
				if (cmd_q == CMD_ADD) begin
					if (found_any) begin
						status_d = ST_EXISTED;
						ctl.op   = apply_go ? CELL_REPLACE : CELL_HOLD;
					end else if (full) begin
						status_d = ST_FULL;
					end else begin
						status_d = ST_NEW;
						ctl.op   = apply_go ? CELL_INSERT : CELL_HOLD;
					end
				end else begin
					if (found_any) begin
						status_d = ST_WITHDREW;
						ctl.op   = apply_go ? CELL_REMOVE : CELL_HOLD;
					end else begin
						status_d = ST_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= apply_go || (rsp_valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= key;
			cmd_q <= cmd_t'(req.cmd);
		end
		if (apply_go) begin
			status_q <= status_d;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   prev_valid;
		route_t prev_entry;
		logic   next_valid;
		route_t next_entry;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_entry = key;
		end else begin : g_body
			assign prev_valid = valid_vec[i-1];
			assign prev_entry = entry_vec[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_entry = key;
		end else begin : g_link
			assign next_valid = valid_vec[i+1];
			assign next_entry = entry_vec[i+1];
		end

		rtu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_valid),
			.prev_entry (prev_entry),
			.next_valid (next_valid),
			.next_entry (next_entry),
			.found_in   (found[i]),
			.valid      (valid_vec[i]),
			.entry      (entry_vec[i]),
			.found_out  (found[i+1])
		);
	end

	assign do_insert = apply_go && (status_d == ST_NEW);
	assign do_remove = apply_go && (status_d == ST_WITHDREW);
	assign valid_cnt = $countones(valid_vec);

	// valid cells stay packed toward the newest end
	`ASSERT_ALWAYS(a_packed, clk, arst_n, 1'b1, (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0)
	`ASSERT_NEXT(a_accept_apply, clk, arst_n, accept, state_q == S_APPLY)
	`ASSERT_NEXT(a_insert_grows, clk, arst_n, do_insert, valid_cnt == $past(valid_cnt) + 1)
	`ASSERT_NEXT(a_remove_shrinks, clk, arst_n, do_remove, valid_cnt + 1 == $past(valid_cnt))

endmodule

// ----- test/tb_route_table_update.sv -----
// Testbench for route_table_update: random and directed add/withdraw beats
// checked against a predicted table. Depends on rtu_pkg, rtu_if and the RTL.
module tb_route_table_update;
	import rtu_pkg::*;

	typedef struct {
		cmd_t   op;
		route_t rt;
		bit     drain;
	} route_req_t;

	logic clk;
	logic arst_n;

	rtu_req_if req_ch ();
	rtu_rsp_if rsp_ch ();

	route_table_update u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	route_req_t  route_q[$];
	status_t     status_q[$];
	int          status_due;
	int          errs;
	int          cyc;
	route_t      tab[TABLE_DEPTH];
	int          tab_cnt;
	route_t      hist[$];
	logic [31:0] bases[22];
	logic [31:0] masks[3];
	logic [31:0] gws[3];
	logic [3:0]  ifcs[3];

	// table kept newest first, entries 0..tab_cnt-1 valid
	function automatic status_t table_update(cmd_t op, route_t r);
		status_t st;
		int      hit;
		hit = -1;
		if (op == CMD_ADD) begin
			for (int i = 0; i < tab_cnt; i++) begin
				if (tab[i] == r) begin
					hit = i;
					break;
				end
				if (tab[i].base == r.base && tab[i].ifc == r.ifc && r.weight < tab[i].weight) begin
					tab[i] = r;
					hit = i;
					break;
				end
			end
			if (hit >= 0)
				st = ST_EXISTED;
			else if (tab_cnt == TABLE_DEPTH)
				st = ST_FULL;
			else begin
				for (int i = tab_cnt; i > 0; i--)
					tab[i] = tab[i - 1];
				tab[0] = r;
				tab_cnt++;
				st = ST_NEW;
			end
		end else begin
			for (int i = 0; i < tab_cnt; i++) begin
				if (tab[i].base == r.base) begin
					hit = i;
					break;
				end
			end
			if (hit >= 0) begin
				for (int j = hit; j < tab_cnt - 1; j++)
					tab[j] = tab[j + 1];
				tab_cnt--;
				st = ST_WITHDREW;
			end else
				st = ST_NOTFOUND;
		end
		return st;
	endfunction

	task automatic push_route(cmd_t op, logic [31:0] b, logic [31:0] m, logic [31:0] g,
			logic [3:0] f, logic [15:0] w, bit drain);
		route_req_t it;
		it.op = op;
		it.rt = '{base: b, mask: m, gateway: g, ifc: f, weight: w};
		it.drain = drain;
		route_q.push_back(it);
	endtask

	function automatic route_t pool_route();
		route_t r;
		r.base = bases[$urandom_range(0, 21)];
		r.mask = masks[$urandom_range(0, 2)];
		r.gateway = gws[$urandom_range(0, 2)];
		r.ifc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : ifcs[$urandom_range(0, 2)];
		case ($urandom_range(0, 9))
			0: r.weight = 16'($urandom);
			1: r.weight = 16'hFFFF;
			default: r.weight = 16'($urandom_range(0, 7));
		endcase
		return r;
	endfunction

	// sender: holds the beat until accepted, random gaps outside the steady window
	always @(posedge clk or negedge arst_n) begin
		route_req_t nxt;
		bit         gap;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			gap = !(cyc >= 1200 && cyc < 2000) && ($urandom_range(0, 99) < 14);
			if (!req_ch.valid || req_ch.ready) begin
				if (route_q.size() != 0 && !gap &&
						!(route_q[0].drain && (req_ch.valid || status_due != 0))) begin
					nxt = route_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= nxt.op;
					req_ch.route_base <= nxt.rt.base;
					req_ch.route_mask <= nxt.rt.mask;
					req_ch.route_gateway <= nxt.rt.gateway;
					req_ch.interface_id <= nxt.rt.ifc;
					req_ch.route_weight <= nxt.rt.weight;
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: predicts on each request beat, checks each status beat
	always @(posedge clk or negedge arst_n) begin
		route_t  seen;
		status_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			status_due <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				seen = route_t'({req_ch.route_base, req_ch.route_mask, req_ch.route_gateway,
					req_ch.interface_id, req_ch.route_weight});
				status_q.push_back(table_update(cmd_t'(req_ch.cmd), seen));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (status_q.size() == 0) begin
					$error("status: expected none actual %0d", rsp_ch.status);
					errs++;
				end else begin
					want = status_q.pop_front();
					if (rsp_ch.status !== want) begin
						$error("status: expected %0d actual %0d", want, rsp_ch.status);
						errs++;
					end
				end
			end
			status_due <= status_q.size();
			rsp_ch.ready <= (cyc >= 1200 && cyc < 2000) || ($urandom_range(0, 99) >= 14);
		end
	end

	initial begin
		#100000;
		$display("tb_route_table_update failed");
		$finish;
	end

	initial begin
		route_t      r;
		logic [31:0] a;
		int          mode;
		int          add_pct;
		int          pick;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ADD;
		req_ch.route_base = '0;
		req_ch.route_mask = '0;
		req_ch.route_gateway = '0;
		req_ch.interface_id = '0;
		req_ch.route_weight = '0;
		rsp_ch.ready = 1'b0;
		errs = 0;
		tab_cnt = 0;

		bases[0] = 32'h0;
		bases[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 22; i++)
			bases[i] = $urandom;
		masks[0] = 32'hFFFF_FF00;
		masks[1] = $urandom;
		masks[2] = $urandom;
		for (int i = 0; i < 3; i++) begin
			gws[i] = $urandom;
			ifcs[i] = 4'($urandom);
		end

		a = $urandom;
		push_route(CMD_WITHDRAW, a, $urandom, $urandom, 4'($urandom), 16'($urandom), 1'b0);
		push_route(CMD_ADD, a, 32'hFFFF_0000, 32'h0A00_0001, 4'd3, 16'd10, 1'b0);
		push_route(CMD_ADD, a, 32'hFFFF_0000, 32'h0A00_0001, 4'd3, 16'd10, 1'b0);
		// equal weight, other gateway: inserted, not replaced
		push_route(CMD_ADD, a, 32'hFFFF_0000, 32'h0A00_0002, 4'd3, 16'd10, 1'b0);
		push_route(CMD_ADD, a, 32'hFFFF_0000, 32'h0A00_0003, 4'd3, 16'd20, 1'b0);
		push_route(CMD_ADD, a, 32'hFFFF_FF00, 32'h0A00_0004, 4'd3, 16'd5, 1'b0);
		push_route(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1'b0);
		push_route(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0, 4'd0, 16'd0, 1'b0);
		push_route(CMD_ADD, a, 32'hFFFF_0000, 32'h0A00_0001, 4'd4, 16'd0, 1'b0);
		// withdraw ignores everything but the base
		push_route(CMD_WITHDRAW, a, $urandom, $urandom, 4'($urandom), 16'($urandom), 1'b0);
		push_route(CMD_WITHDRAW, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1'b0);
		push_route(CMD_WITHDRAW, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 16'd0, 1'b0);
		for (int i = 0; i < 13; i++)
			push_route(CMD_ADD, 32'hC0A8_0000 + i, 32'hFFFF_FF00, 32'hC0A8_00FE, 4'd7,
				16'd100, 1'b0);
		// table full: identical and lower weight still hit, new insert dropped
		push_route(CMD_ADD, 32'hC0A8_000C, 32'hFFFF_FF00, 32'hC0A8_00FE, 4'd7, 16'd100, 1'b0);
		push_route(CMD_ADD, 32'hC0A8_0000, 32'hFFFF_FFFF, 32'hC0A8_00FD, 4'd7, 16'd1, 1'b0);
		push_route(CMD_ADD, 32'hC0A8_0010, 32'hFFFF_FF00, 32'hC0A8_00FE, 4'd7, 16'd100, 1'b0);

		for (int e = 0; e < 21; e++) begin
			mode = $urandom_range(0, 2);
			add_pct = (mode == 0) ? 85 : (mode == 1) ? 55 : 25;
			for (int k = 0; k < 50; k++) begin
				if ($urandom_range(0, 99) < add_pct) begin
					pick = $urandom_range(0, 9);
					if (pick < 2 && hist.size() != 0)
						r = hist[$urandom_range(0, hist.size() - 1)];
					else if (pick < 4 && hist.size() != 0) begin
						r = hist[$urandom_range(0, hist.size() - 1)];
						if (r.weight != 0)
							r.weight = r.weight -
								16'($urandom_range(1, (r.weight < 4) ? r.weight : 4));
						r.gateway = gws[$urandom_range(0, 2)];
					end else if (pick == 4)
						r = route_t'({$urandom, $urandom, $urandom, 4'($urandom), 16'($urandom)});
					else
						r = pool_route();
					hist.push_back(r);
					if (hist.size() > 32)
						void'(hist.pop_front());
					push_route(CMD_ADD, r.base, r.mask, r.gateway, r.ifc, r.weight,
						k == 0 && e % 4 == 3);
				end else begin
					a = ($urandom_range(0, 9) == 0) ? $urandom : bases[$urandom_range(0, 21)];
					push_route(CMD_WITHDRAW, a, $urandom, $urandom, 4'($urandom),
						16'($urandom), k == 0 && e % 4 == 3);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (route_q.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (status_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errs == 0 && status_q.size() == 0)
			$display("tb_route_table_update passed");
		else
			$display("tb_route_table_update failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rtu_pkg.sv
rtl/rtu_if.sv
rtl/rtu_cell.sv
rtl/route_table_update.sv
test/tb_route_table_update.sv
